// ===== hw/rtl/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Types and constants shared by the retransmit timeout table files.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

    localparam int STAMP_W = 32;
    localparam int BUF_W   = 16;
    localparam int HELD_W  = 5;

    localparam logic [31:0] RETRY_RESET   = 32'(2000 * 1000);
    localparam logic [31:0] GIVE_UP_RESET = 32'(3 * 1000 * 1000);

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;
    localparam logic [1:0] CFG_GIVE_UP = 2'd2;

    typedef enum logic [1:0] {
        FN_SEND  = 2'd0,
        FN_TICK  = 2'd1,
        FN_ACK   = 2'd2,
        FN_FLUSH = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        EV_SEND    = 3'd0,
        EV_RESEND  = 3'd1,
        EV_ACKED   = 3'd2,
        EV_EXPIRED = 3'd3,
        EV_FLUSHED = 3'd4,
        EV_NONE    = 3'd5,
        EV_FULL    = 3'd6
    } event_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [BUF_W-1:0]   buf_id;
    } entry_t;

    typedef struct packed {
        event_t           ev;
        logic [BUF_W-1:0] buf_id;
    } result_t;

    typedef struct packed {
        logic        enable;
        logic [31:0] retry_after;
        logic [31:0] give_up_after;
    } cfg_t;

    localparam int ENT_W = $bits(entry_t);
    localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== hw/rtl/rtt_ram.sv =====
// ----------------------------------------------------------------------------
// rtt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtt_ctrl
// Sequencer: stores sends in a ring of entries kept oldest to newest, walks
// the ring newest first for tick, ack and flush while compacting the kept
// entries, queues the events in the result RAM and plays them out.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_ctrl
    import rtt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire func_t                in_func,
    input  wire logic [STAMP_W-1:0]   in_stamp,
    input  wire logic [BUF_W-1:0]     in_buf,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output result_t                   out_res,
    output logic                      out_last,
    output logic                      timer_on,
    output logic [$clog2(SLOTS+1)-1:0] held_cnt,
    output logic                      ent_we,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] ent_waddr,
    output entry_t                    ent_wdata,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] ent_raddr,
    input  wire entry_t               ent_rdata,
    output logic                      res_we,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] res_waddr,
    output result_t                   res_wdata,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] res_raddr,
    input  wire result_t              res_rdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WALK = 5'b00010,
        ST_RD   = 5'b00100,
        ST_LD   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               timer_reg, timer_next;
    func_t              func_reg, func_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   w_reg, w_next;
    logic [CNT_W-1:0]   drop_reg, drop_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   resn_reg, resn_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    result_t            out_res_reg, out_res_next;
    logic               out_last_reg, out_last_next;

    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   pos_m1;
    logic [STAMP_W-1:0] age;
    logic               drop;
    logic               emit;
    event_t             ev;
    logic [CNT_W-1:0]   drop_tot;

    // ring position: (a + b) mod SLOTS, both operands below SLOTS or b == SLOTS
    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {{(SUM_W - IDX_W){1'b0}}, a} + {1'b0, b};
        if (s >= SUM_W'(SLOTS))
        begin
            s = s - SUM_W'(SLOTS);
        end
        return s[IDX_W-1:0];
    endfunction

    assign count_m1  = count_reg - CNT_W'(1);
    assign pos_m1    = pos_reg - IDX_W'(1);
    assign age       = stamp_reg - ent_rdata.stamp;
    assign ent_raddr = (state_reg == ST_WALK) ? wrap(head_reg, CNT_W'(pos_m1))
                                              : wrap(head_reg, CNT_W'(count_m1[IDX_W-1:0]));
    assign res_raddr = k_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;
    assign timer_on  = timer_reg;
    assign held_cnt  = count_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        timer_next    = timer_reg;
        func_next     = func_reg;
        stamp_next    = stamp_reg;
        pos_next      = pos_reg;
        w_next        = w_reg;
        drop_next     = drop_reg;
        found_next    = found_reg;
        resn_next     = resn_reg;
        k_next        = k_reg;
        out_res_next  = out_res_reg;
        out_last_next = out_last_reg;

        ent_we    = 1'b0;
        ent_waddr = wrap(head_reg, CNT_W'(w_reg));
        ent_wdata = ent_rdata;
        res_we    = 1'b0;
        res_waddr = resn_reg[IDX_W-1:0];
        res_wdata = '{ev: EV_NONE, buf_id: '0};

        drop     = 1'b0;
        emit     = 1'b0;
        ev       = EV_NONE;
        drop_tot = drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = in_func;
                    stamp_next = in_stamp;
                    resn_next  = '0;
                    k_next     = '0;
                    pos_next   = count_m1[IDX_W-1:0];
                    w_next     = count_m1[IDX_W-1:0];
                    drop_next  = '0;
                    found_next = 1'b0;
                    if (in_func == FN_FLUSH)
                    begin
                        timer_next = 1'b0;
                        state_next = (count_reg == '0) ? ST_RD : ST_WALK;
                    end
                    else if (!cfg.enable)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        unique case (in_func)
                            FN_SEND:
                            begin
                                res_we     = 1'b1;
                                res_waddr  = '0;
                                resn_next  = CNT_W'(1);
                                state_next = ST_RD;
                                if (count_reg == CNT_W'(SLOTS))
                                begin
                                    res_wdata = '{ev: EV_FULL, buf_id: in_buf};
                                end
                                else
                                begin
                                    res_wdata  = '{ev: EV_SEND, buf_id: in_buf};
                                    ent_we     = 1'b1;
                                    ent_waddr  = wrap(head_reg,
                                                      CNT_W'(count_reg[IDX_W-1:0]));
                                    ent_wdata  = '{stamp: in_stamp, buf_id: in_buf};
                                    count_next = count_reg + CNT_W'(1);
                                    timer_next = 1'b1;
                                end
                            end
                            FN_TICK:
                            begin
                                if (count_reg == '0)
                                begin
                                    timer_next = 1'b0;
                                    state_next = ST_RD;
                                end
                                else
                                begin
                                    state_next = ST_WALK;
                                end
                            end
                            default:
                            begin
                                state_next = (count_reg == '0) ? ST_RD : ST_WALK;
                            end
                        endcase
                    end
                end
            end

            ST_WALK:
            begin
                case (func_reg)
                    FN_FLUSH:
                    begin
                        drop = 1'b1;
                        emit = 1'b1;
                        ev   = EV_FLUSHED;
                    end
                    FN_TICK:
                    begin
                        if (age > cfg.give_up_after)
                        begin
                            drop = 1'b1;
                            emit = 1'b1;
                            ev   = EV_EXPIRED;
                        end
                        else if (age >= cfg.retry_after)
                        begin
                            emit = 1'b1;
                            ev   = EV_RESEND;
                        end
                    end
                    default:
                    begin
                        if (!found_reg && (ent_rdata.stamp == stamp_reg))
                        begin
                            drop       = 1'b1;
                            emit       = 1'b1;
                            ev         = EV_ACKED;
                            found_next = 1'b1;
                        end
                    end
                endcase

                // kept entries slide toward the newest end
                if (!drop)
                begin
                    ent_we = 1'b1;
                    w_next = w_reg - IDX_W'(1);
                end
                if (emit)
                begin
                    res_we    = 1'b1;
                    res_wdata = '{ev: ev, buf_id: ent_rdata.buf_id};
                    resn_next = resn_reg + CNT_W'(1);
                end
                drop_tot  = drop_reg + CNT_W'(drop);
                drop_next = drop_tot;
                pos_next  = pos_m1;
                if (pos_reg == '0)
                begin
                    count_next = count_reg - drop_tot;
                    head_next  = wrap(head_reg, drop_tot);
                    state_next = ST_RD;
                end
            end

            ST_RD:
            begin
                if (resn_reg == '0)
                begin
                    out_res_next  = '{ev: EV_NONE, buf_id: '0};
                    out_last_next = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    state_next = ST_LD;
                end
            end

            ST_LD:
            begin
                out_res_next  = res_rdata;
                out_last_next = ((CNT_W'(k_reg) + CNT_W'(1)) == resn_reg);
                state_next    = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            timer_reg <= 1'b0;
            pos_reg   <= '0;
            w_reg     <= '0;
            drop_reg  <= '0;
            found_reg <= 1'b0;
            resn_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            timer_reg <= timer_next;
            pos_reg   <= pos_next;
            w_reg     <= w_next;
            drop_reg  <= drop_next;
            found_reg <= found_next;
            resn_reg  <= resn_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        stamp_reg    <= stamp_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/retransmit_timeout_table.sv =====
// ----------------------------------------------------------------------------
// retransmit_timeout_table
// Tracks sent packets awaiting acknowledgement and reports resends, expiries,
// acks and flushes as a stream of event beats.
// ----------------------------------------------------------------------------
// One item is handled at a time; s_tready is high only while the block is idle.
// An item that needs no walk is accepted, then its result beat passes through
// the read, load and output states, or read and output alone for a no-event
// beat. Tick, ack (while enabled) and flush walk the N stored entries newest
// first at one entry RAM access per cycle, then play out their R result beats
// the same way, or a single no-event beat; the output state holds while m_tready
// is low. N and R are at most SLOTS. Entries live in a ring in the entry RAM;
// results are queued in a result RAM so that every beat carries the final
// held count and timer flag. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_timeout_table
    import rtt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // stamp[31:0], buf_id[47:32]
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // buf_out[15:0], timer_on[16], held[21:17], zero
    output logic [2:0]       m_tuser,   // event_res[2:0]
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic        enable_reg;
    logic [31:0] retry_reg;
    logic [31:0] give_up_reg;
    cfg_t        cfg;

    result_t          out_res;
    logic             timer_on;
    logic [CNT_W-1:0] held_cnt;

    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    logic [IDX_W-1:0] ent_raddr;
    entry_t           ent_wdata;
    entry_t           ent_rdata;
    logic             res_we;
    logic [IDX_W-1:0] res_waddr;
    logic [IDX_W-1:0] res_raddr;
    result_t          res_wdata;
    result_t          res_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            retry_reg   <= RETRY_RESET;
            give_up_reg <= GIVE_UP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ENABLE:  enable_reg  <= cfg_wdata[0];
                CFG_RETRY:   retry_reg   <= cfg_wdata;
                CFG_GIVE_UP: give_up_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    assign cfg = '{enable: enable_reg, retry_after: retry_reg, give_up_after: give_up_reg};

    rtt_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENT_W)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    rtt_ram #(
        .DEPTH (SLOTS),
        .WIDTH (RES_W)
    ) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    rtt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (func_t'(s_tuser)),
        .in_stamp  (s_tdata[31:0]),
        .in_buf    (s_tdata[47:32]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast),
        .timer_on  (timer_on),
        .held_cnt  (held_cnt),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata),
        .res_we    (res_we),
        .res_waddr (res_waddr),
        .res_wdata (res_wdata),
        .res_raddr (res_raddr),
        .res_rdata (res_rdata)
    );

    assign m_tdata = {2'b00, HELD_W'(held_cnt), timer_on, out_res.buf_id};
    assign m_tuser = out_res.ev;

endmodule

`default_nettype wire

// ===== hw/rtl/rtt_check.sv =====
// ----------------------------------------------------------------------------
// rtt_check
// Port-level checks for the retransmit timeout table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_check
    import rtt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    // one item at a time: never open for input while a beat is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while result pending");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled beat changed");

    a_none_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EV_NONE) |-> (m_tdata[15:0] == 16'd0) && m_tlast)
        else $error("empty event malformed");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (SLOTS > 31) || (m_tdata[21:17] <= 5'(SLOTS)))
        else $error("held count above capacity");

    // an input is taken only after the last beat of the previous one
    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("returned to idle before last beat");

endmodule

bind retransmit_timeout_table rtt_check #(
    .SLOTS (SLOTS)
) u_rtt_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
